FILE: rtl/assert_macros.svh
// Assertion macros for the JTAG shift engine.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JSE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("jse check failed");
`define JSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jse check failed");
`define JSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jse check failed");
`else
`define JSE_ASSERT(lbl, clk, rst_n, prop)
`define JSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define JSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/jse_pkg.sv
// Shared types, constants and helpers for the JTAG shift engine.
// No dependencies; imported by every module of the block.
package jse_pkg;

  localparam int SHIFT_BITS    = 32;
  localparam int PRESCALE_BITS = 8;
  localparam int LEN_W         = $clog2(SHIFT_BITS + 1);
  localparam int IDX_W         = $clog2(SHIFT_BITS);

  typedef logic [SHIFT_BITS-1:0]    word_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [PRESCALE_BITS-1:0] presc_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_RSVD  = 2'd3
  } req_t;

  localparam logic [2:0] REG_LEN  = 3'd0;
  localparam logic [2:0] REG_TDI  = 3'd1;
  localparam logic [2:0] REG_TMS  = 3'd2;
  localparam logic [2:0] REG_TDO  = 3'd3;
  localparam logic [2:0] REG_CTRL = 3'd4;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tck_pin;
    logic        tms_pin;
    logic        tdi_pin;
    logic        trst_pin;
    logic        srst_pin;
    logic        busy_res;
  } res_t;

  function automatic word_t word_from_bus(logic [31:0] d);
    word_t w;
    for (int i = 0; i < SHIFT_BITS; i++) begin
      w[i] = (i < 32) ? d[i % 32] : 1'b0;
    end
    return w;
  endfunction

  function automatic logic [31:0] bus_from_word(word_t w);
    logic [31:0] d;
    for (int i = 0; i < 32; i++) begin
      d[i] = (i < SHIFT_BITS) ? w[i % SHIFT_BITS] : 1'b0;
    end
    return d;
  endfunction

endpackage

FILE: rtl/jtag_shift_engine_unit.sv
// Top level of the JTAG shift engine: engine plus result buffer.
// Depends on jse_pkg, jse_engine, jse_out_buf and assert_macros.svh.
//
//  channel  ports        handshake           width of payload
//  in       in_*         in_valid/in_stall   2 + 3 + 32 + 1 bits
//  out      out_*        out_valid/out_stall 32 + 6 bits
//  cfg      cfg_*        cfg_wr_en           8 bits (prescale)
//
// One request per clock while in_stall is low; its result is registered in the result buffer.
// The state update and output forming sit between the state registers and the
// two-entry result buffer.
// in_stall rises only when both result slots are full.
// Reset (synchronous, rst_n low) clears all registers but the result buffer's data.
`include "assert_macros.svh"

module jtag_shift_engine_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [2:0]            in_reg_index,
  input  logic [31:0]           in_write_data,
  input  logic                  in_tdo_pin,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_read_data,
  output logic                  out_tck_pin,
  output logic                  out_tms_pin,
  output logic                  out_tdi_pin,
  output logic                  out_trst_pin,
  output logic                  out_srst_pin,
  output logic                  out_busy_res,
  input  logic                  cfg_wr_en,
  input  jse_pkg::presc_t       cfg_wr_data
);
  import jse_pkg::*;

  logic accept;
  res_t res, out_res;
  logic buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid & ~buf_full;

  jse_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req_type    (in_req_type),
    .reg_index   (in_reg_index),
    .write_data  (in_write_data),
    .tdo_pin     (in_tdo_pin),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res)
  );

  jse_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_read_data = out_res.read_data;
  assign out_tck_pin   = out_res.tck_pin;
  assign out_tms_pin   = out_res.tms_pin;
  assign out_tdi_pin   = out_res.tdi_pin;
  assign out_trst_pin  = out_res.trst_pin;
  assign out_srst_pin  = out_res.srst_pin;
  assign out_busy_res  = out_res.busy_res;

  `JSE_ASSERT_IMP(a_idle_pins_low, clk, rst_n, out_valid && !out_busy_res,
                  !out_tck_pin && !out_tms_pin && !out_tdi_pin)
  `JSE_ASSERT_IMP(a_skid_implies_main, clk, rst_n, in_stall, out_valid)
  `JSE_ASSERT_NXT(a_accept_gives_result, clk, rst_n, in_valid && !in_stall, out_valid)

endmodule

FILE: rtl/jse_engine.sv
// Register file, TCK divider and shift sequencer of the JTAG shift engine.
// Depends on jse_pkg; one result is formed per accepted request.
module jse_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [1:0]           req_type,
  input  logic [2:0]           reg_index,
  input  logic [31:0]          write_data,
  input  logic                 tdo_pin,
  input  logic                 cfg_wr_en,
  input  jse_pkg::presc_t      cfg_wr_data,
  output jse_pkg::res_t        res
);
  import jse_pkg::*;

  presc_t     prescale_r;
  len_t       bit_length_r, bit_length_nxt;
  word_t      tdi_word_r, tdi_word_nxt;
  word_t      tms_word_r, tms_word_nxt;
  word_t      tdo_word_r, tdo_word_nxt;
  idx_t       bit_index_r, bit_index_nxt;
  presc_t     phase_r, phase_nxt;
  logic       clock_high_r, clock_high_nxt;
  logic       shifting_r, shifting_nxt;
  logic [1:0] reset_bits_r, reset_bits_nxt;
  len_t       idx_inc;
  req_t       req;

  assign req     = req_t'(req_type);
  assign idx_inc = len_t'(bit_index_r) + len_t'(1);

  always_comb begin
    res.read_data = '0;
    if (req == REQ_READ) begin
      case (reg_index)
        REG_LEN:  res.read_data = 32'(bit_length_r);
        REG_TDI:  res.read_data = bus_from_word(tdi_word_r);
        REG_TMS:  res.read_data = bus_from_word(tms_word_r);
        REG_TDO:  res.read_data = bus_from_word(tdo_word_r);
        REG_CTRL: res.read_data = {29'd0, reset_bits_r, shifting_r};
        default:  res.read_data = '0;
      endcase
    end
    res.tck_pin  = shifting_r & clock_high_r;
    res.tms_pin  = shifting_r & tms_word_r[bit_index_r];
    res.tdi_pin  = shifting_r & tdi_word_r[bit_index_r];
    res.trst_pin = reset_bits_r[0];
    res.srst_pin = reset_bits_r[1];
    res.busy_res = shifting_r;
  end

  always_comb begin
    bit_length_nxt = bit_length_r;
    tdi_word_nxt   = tdi_word_r;
    tms_word_nxt   = tms_word_r;
    tdo_word_nxt   = tdo_word_r;
    bit_index_nxt  = bit_index_r;
    phase_nxt      = phase_r;
    clock_high_nxt = clock_high_r;
    shifting_nxt   = shifting_r;
    reset_bits_nxt = reset_bits_r;
    if (accept) begin
      if (shifting_r) begin
        if (phase_r != prescale_r) begin
          phase_nxt = phase_r + presc_t'(1);
        end else begin
          phase_nxt = '0;
          if (!clock_high_r) begin
            clock_high_nxt             = 1'b1;
            tdo_word_nxt[bit_index_r]  = tdo_pin;
          end else begin
            clock_high_nxt = 1'b0;
            if (idx_inc >= bit_length_r) begin
              shifting_nxt  = 1'b0;
              bit_index_nxt = '0;
            end else begin
              bit_index_nxt = idx_inc[IDX_W-1:0];
            end
          end
        end
      end else if (req == REQ_WRITE) begin
        case (reg_index)
          REG_LEN: begin
            if (write_data > 32'(SHIFT_BITS)) bit_length_nxt = len_t'(SHIFT_BITS);
            else bit_length_nxt = write_data[LEN_W-1:0];
          end
          REG_TDI: tdi_word_nxt = word_from_bus(write_data);
          REG_TMS: tms_word_nxt = word_from_bus(write_data);
          REG_CTRL: begin
            reset_bits_nxt = write_data[2:1];
            if (write_data[0]) begin
              tdo_word_nxt   = '0;
              bit_index_nxt  = '0;
              phase_nxt      = '0;
              clock_high_nxt = 1'b0;
              shifting_nxt   = (bit_length_r != '0);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r   <= '0;
      bit_length_r <= '0;
      tdi_word_r   <= '0;
      tms_word_r   <= '0;
      tdo_word_r   <= '0;
      bit_index_r  <= '0;
      phase_r      <= '0;
      clock_high_r <= 1'b0;
      shifting_r   <= 1'b0;
      reset_bits_r <= '0;
    end else begin
      if (cfg_wr_en) prescale_r <= cfg_wr_data;
      bit_length_r <= bit_length_nxt;
      tdi_word_r   <= tdi_word_nxt;
      tms_word_r   <= tms_word_nxt;
      tdo_word_r   <= tdo_word_nxt;
      bit_index_r  <= bit_index_nxt;
      phase_r      <= phase_nxt;
      clock_high_r <= clock_high_nxt;
      shifting_r   <= shifting_nxt;
      reset_bits_r <= reset_bits_nxt;
    end
  end

endmodule

FILE: rtl/jse_out_buf.sv
// Two-entry result register with skid slot for the JTAG shift engine.
// Depends on jse_pkg for the result type.
module jse_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jse_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output jse_pkg::res_t out_data
);
  import jse_pkg::*;

  res_t main_r, skid_r;
  logic main_valid_r, skid_valid_r;
  logic pop;

  assign pop       = main_valid_r & ~out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (pop) begin
          main_r       <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (!main_valid_r || pop) begin
          main_r       <= push_data;
          main_valid_r <= 1'b1;
        end else begin
          skid_r       <= push_data;
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        main_valid_r <= 1'b0;
      end
    end
  end

endmodule
